@@ hw/rtl/kalt_pkg.sv @@
// ----------------------------------------------------------------------------
// kalt_pkg: shared types and constants for the keyed alarm limit table
// Request/result payload structs, opcodes, level codes, presence bit positions
// and the control bundle between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kalt_pkg;

	// opcodes
	localparam logic [2:0] OP_SET      = 3'd0;
	localparam logic [2:0] OP_CLEAR    = 3'd1;
	localparam logic [2:0] OP_QUERY    = 3'd2;
	localparam logic [2:0] OP_CHECK_H  = 3'd3;
	localparam logic [2:0] OP_CHECK_HL = 3'd4;

	// check levels
	localparam logic [1:0] LVL_OK    = 2'd0;
	localparam logic [1:0] LVL_WARN  = 2'd1;
	localparam logic [1:0] LVL_ALARM = 2'd2;

	// presence bit positions
	localparam int PM_GMIN = 0;
	localparam int PM_GMAX = 1;
	localparam int PM_AL   = 2;
	localparam int PM_WL   = 3;
	localparam int PM_WH   = 4;
	localparam int PM_AH   = 5;

	localparam int KEY_W = 24;

	typedef struct packed {
		logic [2:0]         op;
		logic [7:0]         quantity;
		logic [7:0]         instance_req;
		logic [7:0]         subindex;
		logic signed [31:0] gauge_min;
		logic signed [31:0] gauge_max;
		logic signed [31:0] alarm_low;
		logic signed [31:0] warn_low;
		logic signed [31:0] warn_high;
		logic signed [31:0] alarm_high;
		logic [5:0]         present_mask;
		logic signed [31:0] sample;
	} kalt_req_t;

	typedef struct packed {
		logic               accepted;
		logic               found;
		logic signed [31:0] out_gauge_min;
		logic signed [31:0] out_gauge_max;
		logic signed [31:0] out_alarm_low;
		logic signed [31:0] out_warn_low;
		logic signed [31:0] out_warn_high;
		logic signed [31:0] out_alarm_high;
		logic [5:0]         out_present_mask;
		logic [1:0]         level;
		logic [31:0]        version;
	} kalt_rsp_t;

	// one stored limit record
	typedef struct packed {
		logic signed [31:0] gauge_min;
		logic signed [31:0] gauge_max;
		logic signed [31:0] alarm_low;
		logic signed [31:0] warn_low;
		logic signed [31:0] warn_high;
		logic signed [31:0] alarm_high;
		logic [5:0]         presence;
	} kalt_limits_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;    // capture request
		logic lookup;  // key match, table update, record read
		logic finish;  // classify and register result
	} kalt_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/kalt_ram.sv @@
// ----------------------------------------------------------------------------
// kalt_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kalt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/kalt_ctrl.sv @@
// ----------------------------------------------------------------------------
// kalt_ctrl: operation sequencer
// Steps each accepted command through lookup and evaluate phases.
// ----------------------------------------------------------------------------
`default_nettype none

module kalt_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	output kalt_pkg::kalt_cmd_t      cmd
);
	import kalt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EVAL
	} state_t;

	state_t state_q;
	logic   busy_q;

	// state and registered busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOKUP;
						busy_q  <= 1'b1;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_EVAL;
					busy_q  <= 1'b1;
				end
				ST_EVAL: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// commands
	assign busy       = busy_q;
	assign cmd.load   = start && (state_q == ST_IDLE);
	assign cmd.lookup = (state_q == ST_LOOKUP);
	assign cmd.finish = (state_q == ST_EVAL);

endmodule

`default_nettype wire

@@ hw/rtl/kalt_datapath.sv @@
// ----------------------------------------------------------------------------
// kalt_datapath: key match, table storage and classification
// Parallel key compare over the valid entries, lowest free slot pick, limit
// record RAM, version counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kalt_datapath #(
	parameter int ENTRIES = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  kalt_pkg::kalt_cmd_t      cmd,
	input  kalt_pkg::kalt_req_t      req,
	output logic                     done,
	output kalt_pkg::kalt_rsp_t      rsp
);
	import kalt_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int REC_W = $bits(kalt_limits_t);

	kalt_req_t          req_q;
	logic [ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]   key_q [ENTRIES];
	logic [31:0]        ver_q;
	logic               hit_q;
	logic               acc_q;
	logic               done_q;
	kalt_rsp_t          rsp_q;

	logic [KEY_W-1:0]   key;
	logic [ENTRIES-1:0] match;
	logic               hit_any;
	logic               free_any;
	logic [IDX_W-1:0]   hit_idx;
	logic [IDX_W-1:0]   free_idx;
	logic [IDX_W-1:0]   slot;
	logic               do_set;
	logic               do_clear;
	kalt_limits_t       wrec;
	logic [REC_W-1:0]   rdata;
	kalt_limits_t       rrec;
	logic               low;
	logic [1:0]         lvl;
	kalt_rsp_t          rsp_d;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// key compare and priority picks
	assign key = {req_q.quantity, req_q.instance_req, req_q.subindex};

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (key_q[i] == key);
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign hit_any  = |match;
	assign free_any = ~&valid_q;
	assign slot     = hit_any ? hit_idx : free_idx;
	assign do_set   = cmd.lookup && (req_q.op == OP_SET) && (hit_any || free_any);
	assign do_clear = cmd.lookup && (req_q.op == OP_CLEAR) && hit_any;

	// valid bits, version and lookup status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ver_q   <= 32'd1;
			hit_q   <= 1'b0;
			acc_q   <= 1'b0;
		end else if (cmd.lookup) begin
			hit_q <= hit_any;
			acc_q <= do_set || do_clear;
			if (do_set) begin
				valid_q[slot] <= 1'b1;
			end
			if (do_clear) begin
				valid_q[hit_idx] <= 1'b0;
			end
			if (do_set || do_clear) begin
				ver_q <= ver_q + 32'd1;
			end
		end
	end

	// key store
	always_ff @(posedge clk) begin
		if (do_set) begin
			key_q[slot] <= key;
		end
	end

	// limit record store
	assign wrec.gauge_min  = req_q.gauge_min;
	assign wrec.gauge_max  = req_q.gauge_max;
	assign wrec.alarm_low  = req_q.alarm_low;
	assign wrec.warn_low   = req_q.warn_low;
	assign wrec.warn_high  = req_q.warn_high;
	assign wrec.alarm_high = req_q.alarm_high;
	assign wrec.presence   = req_q.present_mask;

	kalt_ram #(
		.WIDTH (REC_W),
		.DEPTH (ENTRIES),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (do_set),
		.waddr (slot),
		.wdata (wrec),
		.re    (cmd.lookup),
		.raddr (hit_idx),
		.rdata (rdata)
	);

	assign rrec = kalt_limits_t'(rdata);

	// classification: alarm before warn, high side before low side
	always_comb begin
		low = (req_q.op == OP_CHECK_HL);
		lvl = LVL_OK;
		if (rrec.presence[PM_AH] && (req_q.sample >= rrec.alarm_high)) begin
			lvl = LVL_ALARM;
		end else if (low && rrec.presence[PM_AL] && (req_q.sample <= rrec.alarm_low)) begin
			lvl = LVL_ALARM;
		end else if (rrec.presence[PM_WH] && (req_q.sample >= rrec.warn_high)) begin
			lvl = LVL_WARN;
		end else if (low && rrec.presence[PM_WL] && (req_q.sample <= rrec.warn_low)) begin
			lvl = LVL_WARN;
		end
	end

	// result assembly
	always_comb begin
		rsp_d          = '0;
		rsp_d.accepted = acc_q;
		rsp_d.found    = hit_q;
		rsp_d.version  = ver_q;
		if (hit_q && (req_q.op == OP_QUERY)) begin
			rsp_d.out_gauge_min    = rrec.gauge_min;
			rsp_d.out_gauge_max    = rrec.gauge_max;
			rsp_d.out_alarm_low    = rrec.alarm_low;
			rsp_d.out_warn_low     = rrec.warn_low;
			rsp_d.out_warn_high    = rrec.warn_high;
			rsp_d.out_alarm_high   = rrec.alarm_high;
			rsp_d.out_present_mask = rrec.presence;
		end
		if (hit_q && ((req_q.op == OP_CHECK_H) || (req_q.op == OP_CHECK_HL))) begin
			rsp_d.level = lvl;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

@@ hw/rtl/keyed_alarm_limit_table.sv @@
// ----------------------------------------------------------------------------
// keyed_alarm_limit_table: associative table of per-sensor alarm limits
// Set, clear, query and threshold check on entries keyed by
// quantity, instance and subindex.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req and raise start; the command transfers at the
//   rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with rsp valid; the
//   receiver must take it then, there is no back-pressure.
// Sequence:
//   The three steps are request capture, key match with table update and
//   record read from the limit RAM (registered read), and classification
//   into the result register; done is high in the cycle after the result
//   register loads. busy is high from the command transfer until the result
//   register loads, so a new command can transfer at the same edge that the
//   previous result transfers.
// Reset:
//   arst_n clears all entry valid bits and sets the version counter to one.
//   Limit RAM contents are not cleared; only records of valid matching entries are used in a result.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_alarm_limit_table #(
	parameter int ENTRIES = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  kalt_pkg::kalt_req_t      req,
	output logic                     done,
	output kalt_pkg::kalt_rsp_t      rsp
);
	import kalt_pkg::*;

	kalt_cmd_t cmd;

	// sequencer
	kalt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// table and classification
	kalt_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
